@@ rtl/thermal_frame_peak_heat_monitor_macros.svh @@
// ----------------------------------------------------------------------------
// thermal frame peak heat monitor assertion macros
// concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef THERMAL_FRAME_PEAK_HEAT_MONITOR_MACROS_SVH
`define THERMAL_FRAME_PEAK_HEAT_MONITOR_MACROS_SVH

`ifndef SYNTHESIS
`define TFPHM_ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: lbl");
`define TFPHM_ASSERT(lbl, prop) `TFPHM_ASSERT_AT(lbl, i_clk, i_rst_n, prop)
`else
`define TFPHM_ASSERT_AT(lbl, clk, rst_n, prop)
`define TFPHM_ASSERT(lbl, prop)
`endif

`endif

@@ rtl/tfphm_pkg.sv @@
// ----------------------------------------------------------------------------
// tfphm_pkg
// shared types and constants of the thermal frame peak heat monitor
// ----------------------------------------------------------------------------
package tfphm_pkg;

    localparam int TEMP_W   = 14;
    localparam int IDX_W    = 10;
    localparam int CNT_W    = 16;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_FAIL  = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_INIT  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_FAULT  = 2'd0,
        MODE_NOHEAT = 2'd1,
        MODE_HEAT   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [CFG_AW-1:0] {
        CFG_HEAT_ON    = 3'd0,
        CFG_HEAT_OFF   = 3'd1,
        CFG_VALID_LOW  = 3'd2,
        CFG_VALID_HIGH = 3'd3,
        CFG_FAST_BLINK = 3'd4,
        CFG_SLOW_BLINK = 3'd5,
        CFG_RETRY      = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic signed [TEMP_W-1:0] heat_on;
        logic signed [TEMP_W-1:0] heat_off;
        logic signed [TEMP_W-1:0] valid_low;
        logic signed [TEMP_W-1:0] valid_high;
        logic        [CNT_W-1:0]  fast_blink;
        logic        [CNT_W-1:0]  slow_blink;
        logic        [CNT_W-1:0]  retry_ticks;
    } t_cfg;

    localparam logic signed [TEMP_W-1:0] RST_HEAT_ON    = 14'sd480;
    localparam logic signed [TEMP_W-1:0] RST_HEAT_OFF   = 14'sd464;
    localparam logic signed [TEMP_W-1:0] RST_VALID_LOW  = -14'sd640;
    localparam logic signed [TEMP_W-1:0] RST_VALID_HIGH = 14'sd4800;
    localparam logic        [CNT_W-1:0]  RST_FAST_BLINK = 16'd100;
    localparam logic        [CNT_W-1:0]  RST_SLOW_BLINK = 16'd1000;
    localparam logic        [CNT_W-1:0]  RST_RETRY      = 16'd1000;
    localparam logic        [CNT_W-1:0]  CNT_MAX        = '1;

    typedef struct packed {
        logic                     ready;
        logic                     fault_enter;
        t_mode                    mode;
        logic                     done;
        logic                     status;
        logic signed [TEMP_W-1:0] peak;
        logic        [IDX_W-1:0]  pixel;
    } t_frame_res;

endpackage

@@ rtl/thermal_frame_peak_heat_monitor.sv @@
// ----------------------------------------------------------------------------
// thermal_frame_peak_heat_monitor
// Input stream: one transfer per item. tuser carries the kind (pixel, frame
// read failure, millisecond tick, sensor init success), tdata the pixel
// temperature and its NaN flag, tlast the final pixel of a frame.
// Output stream: one transfer per input item with led level, mode, frame
// peak and index, and retry request; tlast marks the item that closed a
// frame, tuser flags a frame without any valid pixel.
// Configuration: seven registers written through i_cfg_we / i_cfg_addr /
// i_cfg_wdata; the user writes them only while the stream is idle (the block does not enforce this).
// Path: an input transfer is captured in the input register, which feeds
// the result register, from which the result is offered on the output.
// Throughput: one item per cycle while the output is not stalled, set by the
// combinational compare/update of the frame and led state.
// Reset: synchronous, clears both stream stages, frame state and timers;
// registers return to their defaults and the block waits for init success.
// Stall: a held result keeps the input stage full; while the output stage
// drains, the input register refills in the same cycle, so ready only drops
// when both stages hold data.
// ----------------------------------------------------------------------------
`include "thermal_frame_peak_heat_monitor_macros.svh"

module thermal_frame_peak_heat_monitor #(
    parameter int MAX_PIXELS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tfphm_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [tfphm_pkg::CFG_DW-1:0]        i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // temperature [13:0], not_a_number [14], zero [15]
    input  logic [tfphm_pkg::S_DATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,
    // kind [1:0]
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // led_on [0], app_mode [2:1], max_temperature [16:3], max_pixel [26:17],
    // retry_request [27], zero [31:28]
    output logic [tfphm_pkg::M_DATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tlast,
    // frame_status [0]
    output logic [0:0]                          m_axis_tuser
);

    localparam int TW = tfphm_pkg::TEMP_W;
    localparam int IW = tfphm_pkg::IDX_W;

    tfphm_pkg::t_cfg                r_cfg;

    logic                           r_in_valid;
    tfphm_pkg::t_kind               r_in_kind;
    logic signed [TW-1:0]           r_in_temp;
    logic                           r_in_nan;
    logic                           r_in_last;

    logic                           r_out_valid;
    logic                           r_out_led;
    tfphm_pkg::t_mode               r_out_mode;
    logic                           r_out_done;
    logic                           r_out_status;
    logic signed [TW-1:0]           r_out_peak;
    logic [IW-1:0]                  r_out_pixel;
    logic                           r_out_retry;

    logic                           move;
    tfphm_pkg::t_frame_res          frame_res;
    logic                           led_next;
    logic                           retry_next;

    assign move          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || move;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heat_on     <= tfphm_pkg::RST_HEAT_ON;
            r_cfg.heat_off    <= tfphm_pkg::RST_HEAT_OFF;
            r_cfg.valid_low   <= tfphm_pkg::RST_VALID_LOW;
            r_cfg.valid_high  <= tfphm_pkg::RST_VALID_HIGH;
            r_cfg.fast_blink  <= tfphm_pkg::RST_FAST_BLINK;
            r_cfg.slow_blink  <= tfphm_pkg::RST_SLOW_BLINK;
            r_cfg.retry_ticks <= tfphm_pkg::RST_RETRY;
        end else if (i_cfg_we) begin
            case (tfphm_pkg::t_cfg_reg'(i_cfg_addr))
                tfphm_pkg::CFG_HEAT_ON:    r_cfg.heat_on     <= i_cfg_wdata[TW-1:0];
                tfphm_pkg::CFG_HEAT_OFF:   r_cfg.heat_off    <= i_cfg_wdata[TW-1:0];
                tfphm_pkg::CFG_VALID_LOW:  r_cfg.valid_low   <= i_cfg_wdata[TW-1:0];
                tfphm_pkg::CFG_VALID_HIGH: r_cfg.valid_high  <= i_cfg_wdata[TW-1:0];
                tfphm_pkg::CFG_FAST_BLINK: r_cfg.fast_blink  <= i_cfg_wdata;
                tfphm_pkg::CFG_SLOW_BLINK: r_cfg.slow_blink  <= i_cfg_wdata;
                tfphm_pkg::CFG_RETRY:      r_cfg.retry_ticks <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind <= tfphm_pkg::t_kind'(s_axis_tuser);
            r_in_temp <= s_axis_tdata[TW-1:0];
            r_in_nan  <= s_axis_tdata[TW];
            r_in_last <= s_axis_tlast;
        end
    end

    tfphm_frame #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (move),
        .i_kind  (r_in_kind),
        .i_temp  (r_in_temp),
        .i_nan   (r_in_nan),
        .i_last  (r_in_last),
        .i_cfg   (r_cfg),
        .o_res   (frame_res)
    );

    tfphm_led u_led (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (move),
        .i_kind          (r_in_kind),
        .i_frame         (frame_res),
        .i_cfg           (r_cfg),
        .o_led_on        (led_next),
        .o_retry_request (retry_next)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_led    <= led_next;
            r_out_mode   <= frame_res.mode;
            r_out_done   <= frame_res.done;
            r_out_status <= frame_res.status;
            r_out_peak   <= frame_res.peak;
            r_out_pixel  <= frame_res.pixel;
            r_out_retry  <= retry_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_retry, r_out_pixel, r_out_peak, r_out_mode,
                            r_out_led};
    assign m_axis_tlast  = r_out_done;
    assign m_axis_tuser  = r_out_status;

    `TFPHM_ASSERT(a_heat_led_lit, (r_out_valid && (r_out_mode == tfphm_pkg::MODE_HEAT)) |-> r_out_led)
    `TFPHM_ASSERT(a_status_at_frame_end, (r_out_valid && r_out_status) |-> r_out_done)
    `TFPHM_ASSERT(a_retry_only_faulted, (r_out_valid && r_out_retry) |-> (r_out_mode == tfphm_pkg::MODE_FAULT))
    `TFPHM_ASSERT(a_ready_when_out_free, !r_out_valid |-> s_axis_tready)

endmodule

@@ rtl/tfphm_frame.sv @@
// ----------------------------------------------------------------------------
// tfphm_frame
// per-frame peak tracking, sensor readiness and heat hysteresis
// ----------------------------------------------------------------------------
module tfphm_frame #(
    parameter int MAX_PIXELS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  tfphm_pkg::t_kind                   i_kind,
    input  logic signed [tfphm_pkg::TEMP_W-1:0] i_temp,
    input  logic                               i_nan,
    input  logic                               i_last,
    input  tfphm_pkg::t_cfg                    i_cfg,
    output tfphm_pkg::t_frame_res              o_res
);

    localparam int PW = (MAX_PIXELS > 2) ? $clog2(MAX_PIXELS) : 1;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_PIXELS - 1);

    logic signed [tfphm_pkg::TEMP_W-1:0] r_peak, n_peak;
    logic [PW-1:0]                       r_idx, n_idx;
    logic [PW-1:0]                       r_pos, n_pos;
    logic                                r_any, n_any;
    logic                                r_ready, n_ready;
    logic                                r_heat, n_heat;
    tfphm_pkg::t_mode                    r_mode, n_mode;

    logic                                pix_ok;
    logic [PW+tfphm_pkg::IDX_W-1:0]      idx_wide;

    always_comb begin
        n_peak   = r_peak;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_any    = r_any;
        n_ready  = r_ready;
        n_heat   = r_heat;
        n_mode   = r_mode;
        pix_ok   = 1'b0;
        idx_wide = '0;
        o_res             = '0;
        o_res.ready       = r_ready;
        case (i_kind)
            tfphm_pkg::KIND_PIXEL: begin
                if (r_ready) begin
                    pix_ok = !i_nan && (i_temp >= i_cfg.valid_low)
                             && (i_temp <= i_cfg.valid_high);
                    if (pix_ok && (!r_any || (i_temp > r_peak))) begin
                        n_peak = i_temp;
                        n_idx  = r_pos;
                        n_any  = 1'b1;
                    end
                    if (r_pos < POS_MAX) begin
                        n_pos = r_pos + 1'b1;
                    end
                    if (i_last) begin
                        o_res.done = 1'b1;
                        if (n_any) begin
                            idx_wide    = {{tfphm_pkg::IDX_W{1'b0}}, n_idx};
                            o_res.peak  = n_peak;
                            o_res.pixel = idx_wide[tfphm_pkg::IDX_W-1:0];
                            if (!r_heat) begin
                                if (n_peak >= i_cfg.heat_on) begin
                                    n_heat = 1'b1;
                                end
                            end else if (n_peak < i_cfg.heat_off) begin
                                n_heat = 1'b0;
                            end
                            n_mode = n_heat ? tfphm_pkg::MODE_HEAT : tfphm_pkg::MODE_NOHEAT;
                        end else begin
                            o_res.status      = 1'b1;
                            o_res.fault_enter = 1'b1;
                            n_ready           = 1'b0;
                            n_heat            = 1'b0;
                            n_mode            = tfphm_pkg::MODE_FAULT;
                        end
                        n_peak = '0;
                        n_idx  = '0;
                        n_pos  = '0;
                        n_any  = 1'b0;
                    end
                end
            end
            tfphm_pkg::KIND_FAIL: begin
                if (r_ready) begin
                    o_res.fault_enter = 1'b1;
                    n_ready           = 1'b0;
                    n_heat            = 1'b0;
                    n_mode            = tfphm_pkg::MODE_FAULT;
                    n_peak            = '0;
                    n_idx             = '0;
                    n_pos             = '0;
                    n_any             = 1'b0;
                end
            end
            tfphm_pkg::KIND_INIT: begin
                if (!r_ready) begin
                    n_ready = 1'b1;
                    n_heat  = 1'b0;
                    n_mode  = tfphm_pkg::MODE_NOHEAT;
                    n_peak  = '0;
                    n_idx   = '0;
                    n_pos   = '0;
                    n_any   = 1'b0;
                end
            end
            default: begin
            end
        endcase
        o_res.mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_idx   <= '0;
            r_pos   <= '0;
            r_any   <= 1'b0;
            r_ready <= 1'b0;
            r_heat  <= 1'b0;
            r_mode  <= tfphm_pkg::MODE_FAULT;
        end else if (i_en) begin
            r_peak  <= n_peak;
            r_idx   <= n_idx;
            r_pos   <= n_pos;
            r_any   <= n_any;
            r_ready <= n_ready;
            r_heat  <= n_heat;
            r_mode  <= n_mode;
        end
    end

endmodule

@@ rtl/tfphm_led.sv @@
// ----------------------------------------------------------------------------
// tfphm_led
// status led blink timing and sensor retry timer
// ----------------------------------------------------------------------------
module tfphm_led (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  tfphm_pkg::t_kind      i_kind,
    input  tfphm_pkg::t_frame_res i_frame,
    input  tfphm_pkg::t_cfg       i_cfg,
    output logic                  o_led_on,
    output logic                  o_retry_request
);

    tfphm_pkg::t_mode              r_seen, n_seen;
    logic                          r_led, n_led;
    logic [tfphm_pkg::CNT_W-1:0]   r_blink, n_blink;
    logic [tfphm_pkg::CNT_W-1:0]   r_retry, n_retry;

    logic                          tick;
    logic [tfphm_pkg::CNT_W-1:0]   interval;

    always_comb begin
        n_retry         = r_retry;
        o_retry_request = 1'b0;
        if (i_frame.fault_enter) begin
            n_retry = '0;
        end else if ((i_kind == tfphm_pkg::KIND_TICK) && !i_frame.ready) begin
            if (r_retry != tfphm_pkg::CNT_MAX) begin
                n_retry = r_retry + 1'b1;
            end
            if (n_retry >= i_cfg.retry_ticks) begin
                o_retry_request = 1'b1;
                n_retry         = '0;
            end
        end
    end

    always_comb begin
        n_seen   = r_seen;
        n_led    = r_led;
        n_blink  = r_blink;
        tick     = (i_kind == tfphm_pkg::KIND_TICK);
        interval = (i_frame.mode == tfphm_pkg::MODE_FAULT) ? i_cfg.fast_blink
                                                           : i_cfg.slow_blink;
        if (i_frame.mode != r_seen) begin
            n_seen  = i_frame.mode;
            n_blink = '0;
            n_led   = 1'b0;
            tick    = 1'b0;
        end
        if (i_frame.mode == tfphm_pkg::MODE_HEAT) begin
            n_led = 1'b1;
        end else if (tick) begin
            if (n_blink != tfphm_pkg::CNT_MAX) begin
                n_blink = n_blink + 1'b1;
            end
            if (n_blink >= interval) begin
                n_blink = '0;
                n_led   = ~n_led;
            end
        end
        o_led_on = n_led;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= tfphm_pkg::MODE_NONE;
            r_led   <= 1'b0;
            r_blink <= '0;
            r_retry <= '0;
        end else if (i_en) begin
            r_seen  <= n_seen;
            r_led   <= n_led;
            r_blink <= n_blink;
            r_retry <= n_retry;
        end
    end

endmodule
